FILE: sv/apb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apb_pkg
// Shared types and codes for the aging packet buffer and its cell row.
// ----------------------------------------------------------------------------
package apb_pkg;

  // operation codes
  localparam logic [2:0] OP_ENQUEUE   = 3'd0;
  localparam logic [2:0] OP_DROP_LINK = 3'd1;
  localparam logic [2:0] OP_DEQUEUE   = 3'd2;
  localparam logic [2:0] OP_FIND      = 3'd3;
  localparam logic [2:0] OP_TICK      = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME    = 2'd1;

  localparam logic [6:0]  MAX_ENTRIES_RST = 7'd64;
  localparam logic [31:0] LIFETIME_RST    = 32'd30000;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] packet_id;
    logic [31:0] source_addr;
    logic [31:0] next_hop_addr;
    logic [31:0] dest_addr;
  } req_t;

  typedef struct packed {
    logic        success;
    logic [31:0] out_packet_id;
    logic [31:0] out_source;
    logic [31:0] out_next_hop;
    logic [31:0] out_destination;
    logic        oldest_evicted;
    logic [6:0]  removed_count;
    logic [6:0]  occupancy;
  } rsp_t;

  // one stored descriptor
  typedef struct packed {
    logic [31:0] pid;
    logic [31:0] src;
    logic [31:0] nh;
    logic [31:0] dst;
    logic [31:0] life;
  } entry_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_MARK_LINK,
    CELL_MARK_DST,
    CELL_TICK,
    CELL_SHIFT,
    CELL_INSERT
  } cell_mode_t;

  // control broadcast to every cell
  typedef struct packed {
    cell_mode_t mode;
    logic       ins_en;
    logic       evict;
  } cell_ctl_t;

endpackage

FILE: sv/apb_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apb_cell
// One slot of the age-ordered row: holds a descriptor and its removal mark,
// compares it with the request and shifts down from its upper neighbour.
// ----------------------------------------------------------------------------
module apb_cell (
  input  logic              clk,
  input  apb_pkg::cell_ctl_t ctl,
  input  logic              live,
  input  logic              load,
  input  apb_pkg::entry_t   new_entry,
  input  apb_pkg::entry_t   up_entry,
  input  logic              up_kill,
  input  logic              chain_in,
  output logic              chain_out,
  output logic              hit,
  output logic              dup,
  output apb_pkg::entry_t   entry,
  output logic              kill
);

  logic m_dst;
  logic m_link;
  logic term;

  // key compares against the request
  always_comb begin
    m_dst  = live && (entry.dst == new_entry.dst);
    m_link = live && (entry.src == new_entry.src) && (entry.nh == new_entry.nh);
    dup    = m_link && (entry.dst == new_entry.dst) && (entry.pid == new_entry.pid);
  end

  // prefix chain: first marked cell and everything above it
  always_comb begin
    case (ctl.mode)
      apb_pkg::CELL_MARK_LINK: term = m_link;
      apb_pkg::CELL_MARK_DST:  term = m_dst;
      apb_pkg::CELL_SHIFT:     term = live && kill;
      default:                 term = 1'b0;
    endcase
    chain_out = chain_in | term;
    hit       = term & ~chain_in;
  end

  // slot update
  always_ff @(posedge clk) begin
    case (ctl.mode)
      apb_pkg::CELL_MARK_LINK: kill <= m_link;
      apb_pkg::CELL_MARK_DST:  kill <= hit;
      apb_pkg::CELL_TICK: begin
        kill <= live && (entry.life == 32'd0);
        if (live && (entry.life != 32'd0)) entry.life <= entry.life - 32'd1;
      end
      apb_pkg::CELL_SHIFT: begin
        if (chain_out) begin
          entry <= up_entry;
          kill  <= up_kill;
        end
      end
      apb_pkg::CELL_INSERT: begin
        if (ctl.ins_en) begin
          if (load) entry <= new_entry;
          else if (ctl.evict) entry <= up_entry;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: sv/aging_packet_buffer_with_match_removal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_packet_buffer_with_match_removal
// Age-ordered packet descriptor buffer with duplicate refusal, eviction,
// keyed removal, lookup and lifetime expiry, built as a row of slot cells.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Enqueue, find and
// unused codes finish from the execute state; dequeue, drop_link and tick
// then stay in the shift state while any slot is marked, because the cell row
// closes one gap per cycle by shifting the first marked slot and every slot
// above it down by one. The result is shown for exactly one cycle with done
// high and must be captured then: the receiver cannot stall it. Configuration
// writes are always ready and take effect for the next request.
module aging_packet_buffer_with_match_removal #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  apb_pkg::req_t                     request,
  output logic                              done,
  output apb_pkg::rsp_t                     result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [apb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data
);

  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW = (CW > 7) ? CW : 7;

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_SHIFT} state_t;

  state_t          state;
  apb_pkg::req_t   req;
  logic [CW-1:0]   count;
  logic [CW-1:0]   removed;
  logic [6:0]      max_cfg;
  logic [31:0]     life_cfg;

  apb_pkg::cell_ctl_t ctl;
  apb_pkg::entry_t    new_entry;
  apb_pkg::entry_t    cell_entry [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] cell_kill;
  logic [MAX_ENTRIES-1:0] cell_hit;
  logic [MAX_ENTRIES-1:0] cell_dup;
  logic [MAX_ENTRIES-1:0] cell_live;
  logic [MAX_ENTRIES-1:0] cell_load;
  logic [MAX_ENTRIES:0]   chain;
  logic [CMPW-1:0] cap;
  logic [CMPW-1:0] count_x;
  logic            evict;
  logic            dup_any;
  logic [CW-1:0]   wpos;
  apb_pkg::entry_t hit_entry;
  apb_pkg::rsp_t   result_next;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_cfg  <= apb_pkg::MAX_ENTRIES_RST;
      life_cfg <= apb_pkg::LIFETIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        apb_pkg::CFG_MAX_ENTRIES: max_cfg  <= cfg_data[6:0];
        apb_pkg::CFG_LIFETIME:    life_cfg <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective capacity and eviction decision
  always_comb begin
    count_x = CMPW'(count);
    if (max_cfg == 7'd0) cap = CMPW'(1);
    else if (CMPW'(max_cfg) > CMPW'(MAX_ENTRIES)) cap = CMPW'(MAX_ENTRIES);
    else cap = CMPW'(max_cfg);
    evict   = (count_x >= cap) && (count != '0);
    dup_any = |cell_dup;
    wpos    = count - CW'(evict);
  end

  always_comb begin
    new_entry.pid  = req.packet_id;
    new_entry.src  = req.source_addr;
    new_entry.nh   = req.next_hop_addr;
    new_entry.dst  = req.dest_addr;
    new_entry.life = life_cfg;
  end

  // cell control per state and operation
  always_comb begin
    ctl.mode   = apb_pkg::CELL_HOLD;
    ctl.ins_en = ~dup_any;
    ctl.evict  = evict;
    if (state == ST_EXEC) begin
      case (req.operation) inside
        apb_pkg::OP_ENQUEUE:   ctl.mode = apb_pkg::CELL_INSERT;
        apb_pkg::OP_DROP_LINK: ctl.mode = apb_pkg::CELL_MARK_LINK;
        apb_pkg::OP_DEQUEUE,
        apb_pkg::OP_FIND:      ctl.mode = apb_pkg::CELL_MARK_DST;
        apb_pkg::OP_TICK:      ctl.mode = apb_pkg::CELL_TICK;
        default:               ctl.mode = apb_pkg::CELL_HOLD;
      endcase
    end else if (state == ST_SHIFT) begin
      ctl.mode = apb_pkg::CELL_SHIFT;
    end
  end

  // per-slot live and write-position decode, hit data fold
  always_comb begin
    hit_entry = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      cell_live[i] = (CW'(i) < count);
      cell_load[i] = (CW'(i) == wpos);
      hit_entry    = hit_entry | (cell_entry[i] & {$bits(apb_pkg::entry_t){cell_hit[i]}});
    end
  end

  assign chain[0] = 1'b0;

  // row of slot cells
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    apb_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .live      (cell_live[g]),
      .load      (cell_load[g]),
      .new_entry (new_entry),
      .up_entry  (cell_entry[(g + 1 < MAX_ENTRIES) ? g + 1 : g]),
      .up_kill   ((g + 1 < MAX_ENTRIES) ? cell_kill[(g + 1 < MAX_ENTRIES) ? g + 1 : g] : 1'b0),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1]),
      .hit       (cell_hit[g]),
      .dup       (cell_dup[g]),
      .entry     (cell_entry[g]),
      .kill      (cell_kill[g])
    );
  end

  // next result contents
  always_comb begin
    result_next = result;
    case (state)
      ST_EXEC: begin
        result_next = '0;
        case (req.operation)
          apb_pkg::OP_ENQUEUE: begin
            result_next.success        = ~dup_any;
            result_next.oldest_evicted = ~dup_any & evict;
            if (!dup_any) result_next.occupancy = 7'(count - CW'(evict) + CW'(1));
            else result_next.occupancy = 7'(count);
          end
          apb_pkg::OP_DEQUEUE: begin
            result_next.success         = chain[MAX_ENTRIES];
            result_next.out_packet_id   = hit_entry.pid;
            result_next.out_source      = hit_entry.src;
            result_next.out_next_hop    = hit_entry.nh;
            result_next.out_destination = hit_entry.dst;
          end
          apb_pkg::OP_FIND: begin
            result_next.success   = chain[MAX_ENTRIES];
            result_next.occupancy = 7'(count);
          end
          apb_pkg::OP_DROP_LINK,
          apb_pkg::OP_TICK: ;
          default: result_next.occupancy = 7'(count);
        endcase
      end
      ST_SHIFT: begin
        if (!chain[MAX_ENTRIES]) begin
          if (req.operation != apb_pkg::OP_DEQUEUE) result_next.removed_count = 7'(removed);
          result_next.occupancy = 7'(count);
        end
      end
      default: ;
    endcase
  end

  // sequencer with registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      done    <= 1'b0;
      removed <= '0;
    end else begin
      done   <= 1'b0;
      result <= result_next;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            req   <= request;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          removed <= '0;
          case (req.operation) inside
            apb_pkg::OP_ENQUEUE: begin
              if (!dup_any) count <= count - CW'(evict) + CW'(1);
              done  <= 1'b1;
              state <= ST_IDLE;
            end
            apb_pkg::OP_DEQUEUE,
            apb_pkg::OP_DROP_LINK,
            apb_pkg::OP_TICK: state <= ST_SHIFT;
            default: begin
              done  <= 1'b1;
              state <= ST_IDLE;
            end
          endcase
        end
        ST_SHIFT: begin
          if (chain[MAX_ENTRIES]) begin
            count   <= count - CW'(1);
            removed <= removed + CW'(1);
          end else begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMPW'(count) <= CMPW'(MAX_ENTRIES)) else $error("occupancy above capacity");
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done)) else $error("request not taken");
  a_shift_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT && chain[MAX_ENTRIES]) |=> (count == $past(count) - CW'(1)))
    else $error("compaction did not remove one slot");

endmodule
